FILE: design/srb_pkg.sv
package srb_pkg;

  localparam int unsigned OFF_W    = 62;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned COUNT_W  = 13;

  typedef enum logic {
    ACT_INSERT = 1'b0,
    ACT_DRAIN  = 1'b1
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_STORED  = 3'd0,
    STATUS_DUP     = 3'd1,
    STATUS_BEYOND  = 3'd2,
    STATUS_DRAINED = 3'd3,
    STATUS_EMPTY   = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOCATE,
    ST_READ,
    ST_UPDATE
  } state_t;

  typedef struct packed {
    logic              action;
    logic [OFF_W-1:0]  offset;
    logic [BYTE_W-1:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [BYTE_W-1:0]   out_byte;
    logic [OFF_W-1:0]    delivered_next;
    logic [COUNT_W-1:0]  buffered_count;
  } out_item_t;

  typedef struct packed {
    logic dup;
    logic beyond;
  } loc_t;

endpackage

FILE: design/stream_reassembly_buffer_core.sv
// Channel  Ports                           Moves
// -------  ------------------------------  ---------------------------------
// input    in_valid / in_ready / in_data   insert or drain request item
// output   out_valid / out_ready / out_data status, byte, offset, count item
//
// Each item passes accept, distance compare, slot read and update in turn; the
// registered distance compare and slot store read keep one item in flight.
// After reset the slot store is swept clear, every entry in turn, with in_ready low.
// While a result waits in the output register the next item is taken, but it
// then holds in its update step, with in_ready low, until that register frees.
module stream_reassembly_buffer_core #(
  parameter int unsigned WINDOW = 4096
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  srb_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output srb_pkg::out_item_t out_data
);

  localparam int unsigned SW = $clog2(WINDOW);
  localparam int unsigned CW = $clog2(WINDOW + 1);
  localparam int unsigned MW = srb_pkg::BYTE_W + 1;

  srb_pkg::state_t    state_r, state_nxt;
  srb_pkg::in_item_t  item_r;
  srb_pkg::out_item_t out_r, out_nxt;
  logic               out_valid_r;
  logic [srb_pkg::OFF_W-1:0] delivered_r, delivered_nxt;
  logic [SW-1:0]      del_slot_r, del_slot_nxt;
  logic [CW-1:0]      held_r, held_nxt;
  logic [SW-1:0]      clr_idx_r;
  logic [SW-1:0]      slot_r;
  logic [SW-1:0]      loc_slot;
  srb_pkg::loc_t      loc;

  logic               accept;
  logic               loc_en;
  logic               upd_fire;
  logic               drained;
  logic               ram_we;
  logic [SW-1:0]      ram_waddr;
  logic [MW-1:0]      ram_wdata;
  logic [SW-1:0]      ram_raddr;
  logic [MW-1:0]      ram_rdata;
  logic               upd_we;
  logic [MW-1:0]      upd_wdata;

  srb_locate #(.WINDOW(WINDOW)) u_locate (
    .clk      (clk),
    .en       (loc_en),
    .offset   (item_r.offset),
    .delivered(delivered_r),
    .del_slot (del_slot_r),
    .loc      (loc),
    .slot     (loc_slot)
  );

  // entry: valid mark on top, byte below
  srb_ram #(.WIDTH(MW), .DEPTH(WINDOW)) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      srb_pkg::ST_CLEAR: begin
        if (clr_idx_r == SW'(WINDOW - 1)) begin
          state_nxt = srb_pkg::ST_IDLE;
        end
      end
      srb_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = srb_pkg::ST_LOCATE;
        end
      end
      srb_pkg::ST_LOCATE: state_nxt = srb_pkg::ST_READ;
      srb_pkg::ST_READ:   state_nxt = srb_pkg::ST_UPDATE;
      srb_pkg::ST_UPDATE: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = srb_pkg::ST_IDLE;
        end
      end
      default: state_nxt = srb_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    loc_en    = 1'b0;
    upd_fire  = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = slot_r;
    ram_wdata = upd_wdata;
    ram_raddr = slot_r;
    unique case (state_r)
      srb_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_idx_r;
        ram_wdata = '0;
      end
      srb_pkg::ST_IDLE:   in_ready = 1'b1;
      srb_pkg::ST_LOCATE: loc_en = 1'b1;
      srb_pkg::ST_READ: begin
        ram_raddr = (item_r.action == srb_pkg::ACT_DRAIN) ? del_slot_r : loc_slot;
      end
      srb_pkg::ST_UPDATE: begin
        upd_fire = !out_valid_r || out_ready;
        ram_we   = upd_fire && upd_we;
      end
      default: ;
    endcase
  end

  assign accept = in_valid && in_ready;

  always_comb begin
    delivered_nxt = delivered_r;
    del_slot_nxt  = del_slot_r;
    held_nxt      = held_r;
    upd_we        = 1'b0;
    upd_wdata     = {1'b1, item_r.data_byte};
    drained       = 1'b0;
    out_nxt.out_byte = '0;
    if (item_r.action == srb_pkg::ACT_INSERT) begin
      if (loc.dup) begin
        out_nxt.status = srb_pkg::STATUS_DUP;
      end else if (loc.beyond) begin
        out_nxt.status = srb_pkg::STATUS_BEYOND;
      end else begin
        upd_we         = 1'b1;
        out_nxt.status = srb_pkg::STATUS_STORED;
        if (!ram_rdata[MW-1]) begin
          held_nxt = held_r + CW'(1);
        end
      end
    end else if (ram_rdata[MW-1]) begin
      drained          = 1'b1;
      upd_we           = 1'b1;
      upd_wdata        = '0;
      out_nxt.status   = srb_pkg::STATUS_DRAINED;
      out_nxt.out_byte = ram_rdata[srb_pkg::BYTE_W-1:0];
      if (held_r != '0) begin
        held_nxt = held_r - CW'(1);
      end
      delivered_nxt = delivered_r + srb_pkg::OFF_W'(1);
      // all-ones wraps to zero, and the slot index restarts with it
      if (delivered_r == '1 || del_slot_r == SW'(WINDOW - 1)) begin
        del_slot_nxt = '0;
      end else begin
        del_slot_nxt = del_slot_r + SW'(1);
      end
    end else begin
      out_nxt.status = srb_pkg::STATUS_EMPTY;
    end
    out_nxt.delivered_next = delivered_nxt;
    out_nxt.buffered_count = srb_pkg::COUNT_W'(held_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= srb_pkg::ST_CLEAR;
      clr_idx_r   <= '0;
      out_valid_r <= 1'b0;
      delivered_r <= '0;
      del_slot_r  <= '0;
      held_r      <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == srb_pkg::ST_CLEAR) begin
        clr_idx_r <= clr_idx_r + SW'(1);
      end
      if (upd_fire) begin
        out_valid_r <= 1'b1;
        delivered_r <= delivered_nxt;
        del_slot_r  <= del_slot_nxt;
        held_r      <= held_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_data;
    end
    if (state_r == srb_pkg::ST_READ) begin
      slot_r <= ram_raddr;
    end
    if (upd_fire) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
    held_r <= CW'(WINDOW))
    else $error("held count above window");

  a_slot_bound: assert property (@(posedge clk) disable iff (!rst_n)
    del_slot_r <= SW'(WINDOW - 1))
    else $error("delivered slot out of range");

  a_drain_step: assert property (@(posedge clk) disable iff (!rst_n)
    (upd_fire && drained) |=> delivered_r == $past(delivered_r) + srb_pkg::OFF_W'(1))
    else $error("drain did not advance delivered offset");

  a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
    upd_fire |=> out_valid_r)
    else $error("update lost its result");

  a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != srb_pkg::ST_IDLE) |-> !in_ready)
    else $error("item taken while busy");

endmodule

FILE: design/srb_ram.sv
module srb_ram #(
  parameter int unsigned WIDTH = 9,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: design/srb_locate.sv
module srb_locate #(
  parameter int unsigned WINDOW = 4096
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic [srb_pkg::OFF_W-1:0]     offset,
  input  logic [srb_pkg::OFF_W-1:0]     delivered,
  input  logic [$clog2(WINDOW)-1:0]     del_slot,
  output srb_pkg::loc_t                 loc,
  output logic [$clog2(WINDOW)-1:0]     slot
);

  localparam int unsigned SW = $clog2(WINDOW);

  logic [srb_pkg::OFF_W:0] diff;
  srb_pkg::loc_t           loc_r;
  srb_pkg::loc_t           loc_nxt;
  logic [SW-1:0]           d_low_r;
  logic [SW:0]             sum;

  // borrow out of the wide subtract marks an offset already delivered
  assign diff = {1'b0, offset} - {1'b0, delivered};

  always_comb begin
    loc_nxt.dup    = diff[srb_pkg::OFF_W];
    loc_nxt.beyond = !diff[srb_pkg::OFF_W] &&
                     (diff[srb_pkg::OFF_W-1:0] >= srb_pkg::OFF_W'(WINDOW));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      loc_r   <= loc_nxt;
      d_low_r <= diff[SW-1:0];
    end
  end

  // slot = (del_slot + distance) mod WINDOW, distance < WINDOW when in window
  assign sum  = {1'b0, del_slot} + {1'b0, d_low_r};
  assign slot = (sum >= (SW+1)'(WINDOW)) ? SW'(sum - (SW+1)'(WINDOW)) : sum[SW-1:0];
  assign loc  = loc_r;

endmodule
